>>> rtl/core/monotone_run_labeler_unit_defines.svh
// assertion helpers shared by the run labeller rtl
`ifndef MONOTONE_RUN_LABELER_UNIT_DEFINES_SVH
`define MONOTONE_RUN_LABELER_UNIT_DEFINES_SVH

// same-cycle implication
`define MRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrl assertion failed");

// next-cycle implication
`define MRL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrl assertion failed");

`endif

>>> rtl/core/mrl_pkg.sv
package mrl_pkg;

    // fixed field widths
    localparam int SMP_W   = 16;
    localparam int PAD_W   = 6;
    localparam int LAB_W   = 6;
    localparam int IDX_W   = 7;
    localparam int CIDX_W  = 3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DIRECTION_DOWN = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LEFT_PAD       = 3'd1;
    localparam logic [CIDX_W-1:0] REG_RIGHT_PAD      = 3'd2;
    localparam logic [CIDX_W-1:0] REG_UPPER_ENABLE   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_UPPER_LIMIT    = 3'd4;
    localparam logic [CIDX_W-1:0] REG_LOWER_ENABLE   = 3'd5;
    localparam logic [CIDX_W-1:0] REG_LOWER_LIMIT    = 3'd6;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic                    direction_down;
        logic [PAD_W-1:0]        left_pad;
        logic [PAD_W-1:0]        right_pad;
        logic                    upper_enable;
        logic signed [SMP_W-1:0] upper_limit;
        logic                    lower_enable;
        logic signed [SMP_W-1:0] lower_limit;
    } t_cfg;

    // run tracking state carried between scan steps
    typedef struct packed {
        logic                    empty;
        t_idx                    head;
        t_idx                    last;
        logic signed [SMP_W-1:0] head_val;
        logic signed [SMP_W-1:0] top_val;
        t_idx                    stop_next;
    } t_scan;

    typedef struct packed {
        t_scan scan;
        logic  fill;
        t_idx  fill_lo;
        t_idx  fill_hi;
        logic  last_step;
    } t_step;

endpackage

>>> rtl/core/mrl_intf.sv
interface mrl_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [15:0]        sample;
    logic                      missing;
    logic                      final_sample;
    modport source (output valid, output sample, output missing, output final_sample,
                    input ready);
    modport sink   (input valid, input sample, input missing, input final_sample,
                    output ready);
endinterface

interface mrl_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] run_label;
    logic       final_label;
    modport source (output valid, output run_label, output final_label, input ready);
    modport sink   (input valid, input run_label, input final_label, output ready);
endinterface

interface mrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/monotone_run_labeler_unit.sv
// channel  | dir | handshake          | payload
// i_smp    | in  | valid / ready      | sample, missing, final_sample
// o_res    | out | valid / ready      | run_label, final_label
// i_cfg    | in  | valid / ready (=1) | index, data
//
// loading accepts one item per cycle; after the final item the scan reads the
// stored sequence through the sample memory port, in a read and an evaluate
// state per sample pair, plus one label memory write per labelled sample, then
// each result goes through a read, a load and a send state and waits for ready.
// i_rst_n is synchronous; stores need no clearing, labels are zeroed on load.
`include "monotone_run_labeler_unit_defines.svh"

module monotone_run_labeler_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mrl_in_if.sink   i_smp,
    mrl_out_if.source o_res,
    mrl_cfg_if.sink  i_cfg
);
    import mrl_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = AW + 1;

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_PRE_RD   = 4'd1;
    localparam logic [3:0] ST_PRE_EV   = 4'd2;
    localparam logic [3:0] ST_SCAN_RD  = 4'd3;
    localparam logic [3:0] ST_SCAN_EV  = 4'd4;
    localparam logic [3:0] ST_FILL     = 4'd5;
    localparam logic [3:0] ST_OUT_RD   = 4'd6;
    localparam logic [3:0] ST_OUT_LD   = 4'd7;
    localparam logic [3:0] ST_OUT_SEND = 4'd8;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

    // stores
    logic [SMP_W:0]   smem [MAX_LEN];
    logic [LAB_W-1:0] lmem [MAX_LEN];
    logic [SMP_W:0]   r_smem_q;
    logic [LAB_W-1:0] r_lmem_q;

    t_cfg             r_cfg;
    logic [3:0]       r_state;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_k;
    logic signed [SMP_W-1:0] r_prev_val;
    logic             r_prev_miss;
    t_scan            r_scan;
    logic [LAB_W-1:0] r_count;
    logic [LAB_W-1:0] r_fill_lab;
    logic [CW-1:0]    r_fill_ptr;
    logic [CW-1:0]    r_fill_end;
    logic             r_was_last;
    logic [LAB_W-1:0] r_out_label;
    logic             r_out_final;
    logic             r_out_valid;

    logic             in_acc;
    logic             store_ok;
    logic [CW-1:0]    n_cnt;
    logic [CW-1:0]    rd_idx;
    logic [CW-1:0]    rd_phys;
    logic [CW-1:0]    fill_phys;
    logic             l_we;
    logic [CW-1:0]    l_waddr;
    logic [LAB_W-1:0] l_wdata;
    t_step            step;

    assign i_smp.ready = (r_state == ST_LOAD);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_smp.valid && i_smp.ready;
    assign store_ok    = (r_cnt < MAX_CNT);
    assign n_cnt       = r_cnt + CW'(store_ok);

    assign o_res.valid       = r_out_valid;
    assign o_res.run_label   = r_out_label;
    assign o_res.final_label = r_out_final;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_DIRECTION_DOWN: r_cfg.direction_down <= i_cfg.data[0];
                REG_LEFT_PAD:       r_cfg.left_pad       <= i_cfg.data[PAD_W-1:0];
                REG_RIGHT_PAD:      r_cfg.right_pad      <= i_cfg.data[PAD_W-1:0];
                REG_UPPER_ENABLE:   r_cfg.upper_enable   <= i_cfg.data[0];
                REG_UPPER_LIMIT:    r_cfg.upper_limit    <= i_cfg.data;
                REG_LOWER_ENABLE:   r_cfg.lower_enable   <= i_cfg.data[0];
                REG_LOWER_LIMIT:    r_cfg.lower_limit    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // scan order to load order address mapping
    always_comb begin
        rd_idx    = (r_state == ST_PRE_RD) ? '0 : r_i + CW'(1);
        rd_phys   = r_cfg.direction_down ? (r_n - CW'(1) - rd_idx) : rd_idx;
        fill_phys = r_cfg.direction_down ? (r_n - CW'(1) - r_fill_ptr) : r_fill_ptr;
    end

    // label write port: zero on load, run number on fill
    always_comb begin
        l_we    = 1'b0;
        l_waddr = r_cnt;
        l_wdata = '0;
        if (r_state == ST_FILL) begin
            l_we    = 1'b1;
            l_waddr = fill_phys;
            l_wdata = r_fill_lab;
        end else if (in_acc && store_ok) begin
            l_we = 1'b1;
        end
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (in_acc && store_ok) begin
            smem[r_cnt[AW-1:0]] <= {i_smp.missing, i_smp.sample};
        end
        r_smem_q <= smem[rd_phys[AW-1:0]];
    end

    // label memory
    always_ff @(posedge i_clk) begin
        if (l_we) begin
            lmem[l_waddr[AW-1:0]] <= l_wdata;
        end
        r_lmem_q <= lmem[r_k[AW-1:0]];
    end

    mrl_run_eval u_eval (
        .i_cfg_regs  (r_cfg),
        .i_scan      (r_scan),
        .i_pos       (t_idx'(r_i)),
        .i_len       (t_idx'(r_n)),
        .i_prev_val  (r_prev_val),
        .i_prev_miss (r_prev_miss),
        .i_cur_val   (r_smem_q[SMP_W-1:0]),
        .i_cur_miss  (r_smem_q[SMP_W]),
        .o_step      (step)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_cnt <= n_cnt;
                        if (i_smp.final_sample) begin
                            r_n          <= n_cnt;
                            r_i          <= '0;
                            r_k          <= '0;
                            r_count      <= LAB_W'(1);
                            r_scan       <= '0;
                            r_scan.empty <= 1'b1;
                            r_state      <= (n_cnt >= CW'(2)) ? ST_PRE_RD : ST_OUT_RD;
                        end
                    end
                end
                ST_PRE_RD: begin
                    r_state <= ST_PRE_EV;
                end
                ST_PRE_EV: begin
                    r_prev_val  <= r_smem_q[SMP_W-1:0];
                    r_prev_miss <= r_smem_q[SMP_W];
                    r_state     <= ST_SCAN_RD;
                end
                ST_SCAN_RD: begin
                    r_state <= ST_SCAN_EV;
                end
                ST_SCAN_EV: begin
                    r_scan      <= step.scan;
                    r_prev_val  <= r_smem_q[SMP_W-1:0];
                    r_prev_miss <= r_smem_q[SMP_W];
                    r_i         <= r_i + CW'(1);
                    r_was_last  <= step.last_step;
                    if (step.fill) begin
                        r_fill_lab <= r_count;
                        r_count    <= r_count + LAB_W'(1);
                        r_fill_ptr <= CW'(step.fill_lo);
                        r_fill_end <= CW'(step.fill_hi);
                        r_state    <= ST_FILL;
                    end else if (step.last_step) begin
                        r_state <= ST_OUT_RD;
                    end else begin
                        r_state <= ST_SCAN_RD;
                    end
                end
                ST_FILL: begin
                    r_fill_ptr <= r_fill_ptr + CW'(1);
                    if (r_fill_ptr == r_fill_end) begin
                        r_state <= r_was_last ? ST_OUT_RD : ST_SCAN_RD;
                    end
                end
                ST_OUT_RD: begin
                    r_state <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    // down mode numbers runs from the left of the load order
                    r_out_label <= (r_cfg.direction_down && (r_lmem_q != '0))
                                   ? (r_count - r_lmem_q) : r_lmem_q;
                    r_out_final <= (r_k == r_n - CW'(1));
                    r_out_valid <= 1'b1;
                    r_state     <= ST_OUT_SEND;
                end
                ST_OUT_SEND: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_final) begin
                            r_cnt   <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // checks
    `MRL_ASSERT_IMP(a_no_load_while_out, i_clk, i_rst_n, o_res.valid, !i_smp.ready)
    `MRL_ASSERT_NXT(a_cnt_cleared, i_clk, i_rst_n,
        o_res.valid && o_res.ready && o_res.final_label, r_cnt == '0)
    `MRL_ASSERT_IMP(a_fill_label_nonzero, i_clk, i_rst_n, r_state == ST_FILL,
        r_fill_lab != '0)

endmodule

>>> rtl/core/mrl_run_eval.sv
module mrl_run_eval (
    input  mrl_pkg::t_cfg  i_cfg_regs,
    input  mrl_pkg::t_scan i_scan,
    input  mrl_pkg::t_idx  i_pos,
    input  mrl_pkg::t_idx  i_len,
    input  logic signed [15:0] i_prev_val,
    input  logic           i_prev_miss,
    input  logic signed [15:0] i_cur_val,
    input  logic           i_cur_miss,
    output mrl_pkg::t_step o_step
);
    import mrl_pkg::*;

    logic              dna;
    logic signed [SMP_W:0] diff;
    logic              pos;
    logic              neg;
    logic              open_now;
    t_scan             sa;
    logic              last_step;
    logic              close;
    logic              reject;
    t_idx              sb;
    t_idx              eb;
    t_idx              gap_l;
    t_idx              bl;
    t_idx              t0;
    t_idx              gap_r;
    t_idx              br;
    logic              off;

    // difference of the pair and its sign
    always_comb begin
        dna  = i_prev_miss | i_cur_miss;
        diff = {i_cur_val[SMP_W-1], i_cur_val} - {i_prev_val[SMP_W-1], i_prev_val};
        pos  = !dna && !diff[SMP_W] && (diff != '0);
        neg  = !dna && diff[SMP_W];
    end

    // run extension on a rising step
    always_comb begin
        open_now = pos && i_scan.empty;
        sa       = i_scan;
        if (pos) begin
            sa.empty = 1'b0;
            sa.last  = i_pos;
            sa.top_val = i_cur_val;
        end
        if (open_now) begin
            sa.head     = i_pos;
            sa.head_val = i_prev_val;
        end
    end

    // run close, limit check and padding
    always_comb begin
        last_step = (i_pos == i_len - t_idx'(2));
        close     = last_step | dna | neg;
        reject    = (i_cfg_regs.upper_enable && (sa.top_val < i_cfg_regs.upper_limit)) ||
                    (i_cfg_regs.lower_enable && (sa.head_val > i_cfg_regs.lower_limit));
        sb = i_cfg_regs.direction_down ? t_idx'(i_cfg_regs.right_pad)
                                       : t_idx'(i_cfg_regs.left_pad);
        eb = i_cfg_regs.direction_down ? t_idx'(i_cfg_regs.left_pad)
                                       : t_idx'(i_cfg_regs.right_pad);
        gap_l = sa.head - sa.stop_next;
        bl    = (gap_l > sb) ? sb : gap_l;
        t0    = sa.last + t_idx'(1);
        off   = last_step && !dna && !diff[SMP_W];
        gap_r = i_pos - t0 + t_idx'(off);
        br    = (gap_r > eb) ? eb : gap_r;
        if (t0 == i_pos + t_idx'(1)) begin
            br = '0;
        end

        o_step.scan      = sa;
        o_step.fill      = close && !sa.empty && !reject;
        o_step.fill_lo   = sa.head - bl;
        o_step.fill_hi   = t0 + br;
        o_step.last_step = last_step;
        if (close) begin
            o_step.scan.empty     = 1'b1;
            o_step.scan.stop_next = i_pos + t_idx'(1);
        end
    end

endmodule
